### src/gfd_pkg.sv
// gfd_pkg: shared constants for the grid factor decomposition block
// no dependencies; imported by grid_factor_decomposition_top
package gfd_pkg;

  // width of every factor field and of the count field on the ports
  localparam int FieldWidth = 16;

  // default internal width of the processor count
  localparam int CountWidthDefault = 16;

  // status codes
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusInvalid = 1'b1;

endpackage

### src/grid_factor_decomposition_top.sv
// grid_factor_decomposition_top: balanced 3d factorisation of a processor count
// depends on gfd_pkg (field width, status codes)
//
// A zero count is answered in the cycle after start. Otherwise the sequencer
// runs an integer root search and then tries each divisor candidate from the
// root upward with the one-bit-per-cycle restoring divider, first for the
// cube-root stage and then for the square-root stage. One request at a time:
// busy is high until the result strobe. Results cannot be stalled.
// Reset (rst, synchronous) returns the sequencer to idle and clears done.
module grid_factor_decomposition_top
  import gfd_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [FieldWidth-1:0] proc_count,
  output logic                  done,
  output logic [FieldWidth-1:0] factor_first,
  output logic [FieldWidth-1:0] factor_second,
  output logic [FieldWidth-1:0] factor_third,
  output logic                  status
);

  localparam int W      = COUNT_WIDTH;
  localparam int AccW   = COUNT_WIDTH + 2;
  localparam int CntW   = $clog2(COUNT_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_TEST,
    S_DIV,
    S_CHECK,
    S_FOUND
  } state_t;

  state_t            state;
  logic              stage;      // 0: cube-root stage, 1: square-root stage
  logic [W-1:0]      v;          // value being factored in this stage
  logic [W-1:0]      r;          // root candidate
  logic [AccW-1:0]   sq;         // r*r
  logic [AccW-1:0]   cube;       // r*r*r
  logic [W-1:0]      cand;       // divisor candidate
  logic [W-1:0]      rem;
  logic [W-1:0]      quo;
  logic [CntW-1:0]   cnt;
  logic [W-1:0]      found_div;
  logic [W-1:0]      found_quo;
  logic [W-1:0]      d0;

  // shared root-step arithmetic
  logic [AccW-1:0] r_ext;
  logic [AccW-1:0] root_target;
  logic            root_reached;
  logic [AccW-1:0] sq_next;
  logic [AccW-1:0] cube_next;

  // restoring divider step
  logic [W:0]      rem_sh;
  logic            sub_ok;
  logic [W:0]      rem_diff;

  logic [W-1:0]    m_in;

  assign m_in = W'(proc_count);

  always_comb begin
    r_ext        = AccW'(r);
    root_target  = stage ? sq : cube;
    root_reached = root_target >= AccW'(v);
    sq_next      = sq + (r_ext << 1) + AccW'(1);
    cube_next    = cube + (sq << 1) + sq + (r_ext << 1) + r_ext + AccW'(1);
  end

  always_comb begin
    rem_sh   = {rem, quo[W-1]};
    sub_ok   = rem_sh >= {1'b0, cand};
    rem_diff = rem_sh - {1'b0, cand};
  end

  assign busy = (state != S_IDLE);

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      stage <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (m_in == '0) begin
              factor_first  <= '0;
              factor_second <= '0;
              factor_third  <= '0;
              status        <= StatusInvalid;
              done          <= 1'b1;
            end else begin
              v     <= m_in;
              r     <= W'(1);
              sq    <= AccW'(1);
              cube  <= AccW'(1);
              stage <= 1'b0;
              state <= S_ROOT;
            end
          end
        end
        // integer root search, one candidate a cycle
        S_ROOT: begin
          if (root_reached) begin
            cand  <= r;
            state <= S_TEST;
          end else begin
            r    <= r + W'(1);
            sq   <= sq_next;
            cube <= cube_next;
          end
        end
        // candidate range exhausted: the value itself is the divisor; else divide by cand
        S_TEST: begin
          if (cand >= v) begin
            found_div <= v;
            found_quo <= W'(1);
            state     <= S_FOUND;
          end else begin
            rem   <= '0;
            quo   <= v;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (sub_ok) begin
            rem <= rem_diff[W-1:0];
          end else begin
            rem <= rem_sh[W-1:0];
          end
          quo <= {quo[W-2:0], sub_ok};
          cnt <= cnt + CntW'(1);
          if (cnt == CntW'(W - 1)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (rem == '0) begin
            found_div <= cand;
            found_quo <= quo;
            state     <= S_FOUND;
          end else begin
            cand  <= cand + W'(1);
            state <= S_TEST;
          end
        end
        S_FOUND: begin
          if (!stage) begin
            d0    <= found_div;
            v     <= found_quo;
            r     <= W'(1);
            sq    <= AccW'(1);
            cube  <= AccW'(1);
            stage <= 1'b1;
            state <= S_ROOT;
          end else begin
            factor_first  <= FieldWidth'(d0);
            factor_second <= FieldWidth'(found_div);
            factor_third  <= FieldWidth'(found_quo);
            status        <= StatusOk;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
